### rtl/core/texture_descriptor_decode_core_macros.svh
// Assertion helpers for the texture descriptor decode core.
// The clock is clk and the reset is arst_n in every module that uses them.
`ifndef TEXTURE_DESCRIPTOR_DECODE_CORE_MACROS_SVH
`define TEXTURE_DESCRIPTOR_DECODE_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define TDD_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TDD_ASSERT(label, ante, cons, msg)
`define TDD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/tdd_pkg.sv
`timescale 1ns / 1ps

package tdd_pkg;

	// Video memory size in bytes (power of two).
	localparam int VIDEO_MEMORY_BYTES = 8388608;

	localparam int SA_W    = 24;                 // data address width
	localparam int REM_W   = SA_W - 1;           // room >> 2 at most
	localparam int QUO_W   = 10;                 // rows in a clipped texture stay below 1024
	localparam int MULT_W  = 5;                  // stride units
	localparam int SHIFT_W = 4;
	localparam int DSH_W   = MULT_W + QUO_W - 1;
	localparam int PROD_W  = QUO_W + MULT_W;
	localparam int SCALED_W = PROD_W + (2 ** SHIFT_W) - 1;

	localparam int DIV_STAGES = 5;
	localparam int DIV_STEPS  = QUO_W / DIV_STAGES;

	localparam logic [SA_W-1:0] VMEM_MASK = SA_W'(VIDEO_MEMORY_BYTES - 1);
	localparam logic [SA_W:0]   VMEM      = (SA_W + 1)'(VIDEO_MEMORY_BYTES);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_STRIDE_UNITS = '0;

	// Pixel formats
	localparam logic [2:0] FMT_ARGB1555 = 3'd0;
	localparam logic [2:0] FMT_RGB565   = 3'd1;
	localparam logic [2:0] FMT_ARGB4444 = 3'd2;
	localparam logic [2:0] FMT_YUV422   = 3'd3;
	localparam logic [2:0] FMT_BUMP     = 3'd4;
	localparam logic [2:0] FMT_PAL4     = 3'd5;
	localparam logic [2:0] FMT_PAL8     = 3'd6;
	localparam logic [2:0] FMT_RESERVED = 3'd7;

	// log2 of bits per pixel
	localparam logic [2:0] PIX_LOG2_4  = 3'd2;
	localparam logic [2:0] PIX_LOG2_8  = 3'd3;
	localparam logic [2:0] PIX_LOG2_16 = 3'd4;

	// Converter path bits
	localparam int PATH_PLANAR   = 0;
	localparam int PATH_TWIDDLED = 1;
	localparam int PATH_VQ       = 2;

	// Top mip level offset by width code
	localparam logic [16:0] MIP_OFFSET [8] = '{
		17'h00006, 17'h00016, 17'h00056, 17'h00156,
		17'h00556, 17'h01556, 17'h05556, 17'h15556
	};

	typedef enum logic [1:0] {
		KIND_PLANAR   = 2'd0,
		KIND_TWIDDLED = 2'd1,
		KIND_VQ       = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_UNSUPPORTED = 2'd1,
		STAT_INVALID     = 2'd2
	} status_t;

	typedef struct packed {
		logic [10:0]     width;
		logic [10:0]     height;
		logic [22:0]     base_address;
		logic [SA_W-1:0] data_address;
		logic [22:0]     table_pointer;
		logic [10:0]     row_stride;
		kind_t           kind;
		logic [4:0]      pixel_bits;
	} tdd_desc_t;

	typedef struct packed {
		tdd_desc_t          desc;
		logic               ok;
		logic [21:0]        size;
		logic [MULT_W-1:0]  mult;
		logic [SHIFT_W-1:0] shift;
	} tdd_dec_t;

	typedef struct packed {
		tdd_desc_t          desc;
		status_t            status;
		logic [21:0]        byte_size;
		logic [10:0]        rows_read;
		logic               clip;
		logic [MULT_W-1:0]  mult;
		logic [SHIFT_W-1:0] shift;
	} tdd_item_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DSH_W-1:0] dsh;
		logic [QUO_W-1:0] quo;
	} tdd_div_t;

	function automatic logic [2:0] pix_log2(input logic [2:0] fmt);
		logic [2:0] lb;
		case (fmt)
			FMT_PAL4: lb = PIX_LOG2_4;
			FMT_PAL8: lb = PIX_LOG2_8;
			default:  lb = PIX_LOG2_16;
		endcase
		return lb;
	endfunction

	// {vq, twiddled, planar}
	function automatic logic [2:0] fmt_paths(input logic [2:0] fmt);
		logic [2:0] p;
		case (fmt)
			FMT_BUMP:           p = 3'b000;
			FMT_PAL4, FMT_PAL8: p = 3'b010;
			default:            p = 3'b111;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/texture_descriptor_decode_core.sv
`timescale 1ns / 1ps
//  channel   direction  handshake                 payload
//  in        request    in_valid / in_stall       descriptor fields, one port each
//  out       result     out_valid / out_stall     decoded texture fields, one port each
//  apb       config     psel penable pwrite pready stride_units at byte address 0
//
//  Takes one request per cycle unless in_stall is high; a request passes through
//  decode, range check, five divider stages (two quotient bits each) and the
//  output register.
//  Reset clears every stage valid bit and stride_units; payload registers are not reset.
//  An empty stage takes new data even while later stages stall, so bubbles close up
//  and in_stall rises only when all eight stages hold a request and out_stall is high.

`include "texture_descriptor_decode_core_macros.svh"

module texture_descriptor_decode_core (
	input  logic        clk,
	input  logic        arst_n,

	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  size_code_u,
	input  logic [2:0]  size_code_v,
	input  logic [20:0] texture_address,
	input  logic [2:0]  pixel_format,
	input  logic        planar_order,
	input  logic        vq_compressed,
	input  logic        mipmapped,
	input  logic        stride_select,
	input  logic [5:0]  palette_select,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] width,
	output logic [10:0] height,
	output logic [22:0] base_address,
	output logic [23:0] data_address,
	output logic [22:0] table_pointer,
	output logic [10:0] row_stride,
	output logic [21:0] byte_size,
	output logic [10:0] rows_read,
	output logic [1:0]  converter_kind,
	output logic [4:0]  pixel_bits,
	output logic [1:0]  status,

	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tdd_pkg::*;

	localparam int NSTAGE = DIV_STAGES + 3;

	logic              cfg_write;
	logic [4:0]        stride_units_q;

	logic [NSTAGE-1:0] load;
	logic [NSTAGE-1:0] stage_valid;

	logic              valid_s1;
	tdd_dec_t          dec_s1;

	logic [DIV_STAGES:0] dv;
	tdd_item_t           di [DIV_STAGES+1];
	tdd_div_t            dd [DIV_STAGES+1];

	logic [PROD_W-1:0]   scaled;
	logic [SCALED_W-1:0] scaled_sh;
	tdd_item_t           fin;

	logic      valid_s8;
	tdd_item_t res_s8;

	// ---------------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_units_q <= '0;
		end else if (cfg_write && paddr[PADDR_W-1:2] == REG_STRIDE_UNITS) begin
			stride_units_q <= pwdata[4:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_STRIDE_UNITS) begin
			prdata = 32'(stride_units_q);
		end
	end

	// ---------------------------------------------------------------------
	// Stage advance: a stage loads when it is empty or its successor loads
	// ---------------------------------------------------------------------
	assign stage_valid = {valid_s8, dv, valid_s1};

	always_comb begin
		load[NSTAGE-1] = !valid_s8 || !out_stall;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			load[k] = !stage_valid[k] || load[k+1];
		end
	end

	assign in_stall = !load[0];

	// ---------------------------------------------------------------------
	// Stage 1: decode sizes, addresses, formats and converter path
	// ---------------------------------------------------------------------
	tdd_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (load[0]),
		.up_valid        (in_valid),
		.size_code_u     (size_code_u),
		.size_code_v     (size_code_v),
		.texture_address (texture_address),
		.pixel_format    (pixel_format),
		.planar_order    (planar_order),
		.vq_compressed   (vq_compressed),
		.mipmapped       (mipmapped),
		.stride_select   (stride_select),
		.palette_select  (palette_select),
		.stride_units    (stride_units_q),
		.dn_valid        (valid_s1),
		.dn_dec          (dec_s1)
	);

	// ---------------------------------------------------------------------
	// Stage 2: status, memory range check, divider setup
	// ---------------------------------------------------------------------
	tdd_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load[1]),
		.up_valid (valid_s1),
		.up_dec   (dec_s1),
		.dn_valid (dv[0]),
		.dn_item  (di[0]),
		.dn_div   (dd[0])
	);

	// ---------------------------------------------------------------------
	// Stages 3..7: rows that fit, by restoring division over the stride
	// ---------------------------------------------------------------------
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		tdd_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load[g+2]),
			.up_valid (dv[g]),
			.up_item  (di[g]),
			.up_div   (dd[g]),
			.dn_valid (dv[g+1]),
			.dn_item  (di[g+1]),
			.dn_div   (dd[g+1])
		);
	end

	// ---------------------------------------------------------------------
	// Stage 8: rebuild the byte size of a clipped texture, output register
	// ---------------------------------------------------------------------
	always_comb begin
		fin       = di[DIV_STAGES];
		scaled    = PROD_W'(dd[DIV_STAGES].quo) * PROD_W'(di[DIV_STAGES].mult);
		scaled_sh = SCALED_W'(scaled) << di[DIV_STAGES].shift;
		if (fin.clip) begin
			fin.rows_read = 11'(dd[DIV_STAGES].quo);
			fin.byte_size = 22'(scaled_sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (load[NSTAGE-1]) begin
			valid_s8 <= dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (load[NSTAGE-1] && dv[DIV_STAGES]) begin
			res_s8 <= fin;
		end
	end

	assign out_valid      = valid_s8;
	assign width          = res_s8.desc.width;
	assign height         = res_s8.desc.height;
	assign base_address   = res_s8.desc.base_address;
	assign data_address   = res_s8.desc.data_address;
	assign table_pointer  = res_s8.desc.table_pointer;
	assign row_stride     = res_s8.desc.row_stride;
	assign byte_size      = res_s8.byte_size;
	assign rows_read      = res_s8.rows_read;
	assign converter_kind = res_s8.desc.kind;
	assign pixel_bits     = res_s8.desc.pixel_bits;
	assign status         = res_s8.status;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`TDD_ASSERT(a_stall_only_full, in_stall, &stage_valid, "request stalled with a free stage")
	`TDD_ASSERT(a_unsup_empty, out_valid && status == STAT_UNSUPPORTED, byte_size == '0 && rows_read == '0, "unsupported result reads memory")
	`TDD_ASSERT(a_read_in_memory, out_valid && status == STAT_OK, 25'(data_address) + 25'(byte_size) <= VMEM, "read runs past video memory")
	`TDD_ASSERT(a_rows_bound, out_valid, rows_read <= height, "more rows than the texture height")

endmodule

### rtl/core/tdd_decode.sv
`timescale 1ns / 1ps

module tdd_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             up_valid,
	input  logic [2:0]       size_code_u,
	input  logic [2:0]       size_code_v,
	input  logic [20:0]      texture_address,
	input  logic [2:0]       pixel_format,
	input  logic             planar_order,
	input  logic             vq_compressed,
	input  logic             mipmapped,
	input  logic             stride_select,
	input  logic [5:0]       palette_select,
	input  logic [4:0]       stride_units,
	output logic             dn_valid,
	output tdd_pkg::tdd_dec_t dn_dec
);
	import tdd_pkg::*;

	logic [2:0]         lb;
	logic [2:0]         paths;
	logic [10:0]        w;
	logic [10:0]        stride;
	logic [19:0]        mip_add;
	logic [SHIFT_W-1:0] size_sh;
	tdd_dec_t           dec;

	logic     valid_s1;
	tdd_dec_t dec_s1;

	always_comb begin
		lb      = pix_log2(pixel_format);
		paths   = fmt_paths(pixel_format);
		w       = 11'(11'd8 << size_code_u);
		size_sh = SHIFT_W'(size_code_v) + SHIFT_W'(lb);
		stride  = w;
		mip_add = '0;

		dec.desc.width        = w;
		dec.desc.height       = 11'(11'd8 << size_code_v);
		dec.desc.pixel_bits   = 5'(5'd1 << lb);
		dec.desc.base_address = 23'({texture_address, 3'b000} & VMEM_MASK);

		// palette index, or codebook at base for VQ
		dec.desc.table_pointer = '0;
		if (lb == PIX_LOG2_4) begin
			dec.desc.table_pointer = 23'({palette_select, 4'b0000});
		end else if (lb == PIX_LOG2_8) begin
			dec.desc.table_pointer = 23'({palette_select[5:4], 8'h00});
		end
		if (vq_compressed) begin
			dec.desc.table_pointer = dec.desc.base_address;
		end

		if (planar_order) begin
			dec.desc.kind = KIND_PLANAR;
			dec.ok        = paths[PATH_PLANAR];
			if (stride_select) begin
				stride = 11'({stride_units, 5'b00000});
			end
			dec.size = 22'(stride) << size_sh;
		end else if (vq_compressed) begin
			dec.desc.kind = KIND_VQ;
			dec.ok        = paths[PATH_VQ];
			if (mipmapped) begin
				mip_add = 20'(MIP_OFFSET[size_code_u]);
			end
			dec.size = 22'(w) << size_code_v;
		end else begin
			dec.desc.kind = KIND_TWIDDLED;
			dec.ok        = paths[PATH_TWIDDLED];
			if (mipmapped) begin
				mip_add = 20'(MIP_OFFSET[size_code_u]) << (lb - 3'd1);
			end
			dec.size = 22'(w) << size_sh;
		end

		dec.desc.row_stride   = stride;
		dec.desc.data_address = SA_W'(dec.desc.base_address) + SA_W'(mip_add);

		// rows = (room >> shift) / mult, size = (rows * mult) << shift
		if (planar_order && stride_select) begin
			dec.mult  = stride_units;
			dec.shift = SHIFT_W'(lb) + SHIFT_W'(2);
		end else begin
			dec.mult  = MULT_W'(1);
			dec.shift = SHIFT_W'(size_code_u) + SHIFT_W'(lb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			dec_s1 <= dec;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_dec   = dec_s1;

endmodule

### rtl/core/tdd_classify.sv
`timescale 1ns / 1ps

module tdd_classify (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               up_valid,
	input  tdd_pkg::tdd_dec_t  up_dec,
	output logic               dn_valid,
	output tdd_pkg::tdd_item_t dn_item,
	output tdd_pkg::tdd_div_t  dn_div
);
	import tdd_pkg::*;

	logic [SA_W:0] sa_ext;
	logic [SA_W:0] end_addr;
	logic [SA_W:0] room;
	tdd_item_t     item;
	tdd_div_t      div;

	logic      valid_s2;
	tdd_item_t item_s2;
	tdd_div_t  div_s2;

	always_comb begin
		sa_ext   = {1'b0, up_dec.desc.data_address};
		end_addr = sa_ext + (SA_W + 1)'(up_dec.size);
		room     = VMEM - sa_ext;

		item.desc      = up_dec.desc;
		item.mult      = up_dec.mult;
		item.shift     = up_dec.shift;
		item.status    = STAT_OK;
		item.byte_size = up_dec.size;
		item.rows_read = up_dec.desc.height;
		item.clip      = 1'b0;

		if (!up_dec.ok) begin
			item.status    = STAT_UNSUPPORTED;
			item.byte_size = '0;
			item.rows_read = '0;
		end else if (up_dec.size == '0) begin
			// planar stride of zero
			item.status    = STAT_INVALID;
			item.byte_size = 22'd4;
			item.rows_read = '0;
		end else if (sa_ext > VMEM) begin
			item.status    = STAT_INVALID;
			item.byte_size = '0;
			item.rows_read = '0;
		end else if (end_addr > VMEM) begin
			item.clip = 1'b1;
		end

		// divider start: dividend is the room in stride-sized units
		div.rem = REM_W'(room >> up_dec.shift);
		div.dsh = DSH_W'(up_dec.mult) << (QUO_W - 1);
		div.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			item_s2 <= item;
			div_s2  <= div;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;
	assign dn_div   = div_s2;

endmodule

### rtl/core/tdd_div_stage.sv
`timescale 1ns / 1ps

module tdd_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               up_valid,
	input  tdd_pkg::tdd_item_t up_item,
	input  tdd_pkg::tdd_div_t  up_div,
	output logic               dn_valid,
	output tdd_pkg::tdd_item_t dn_item,
	output tdd_pkg::tdd_div_t  dn_div
);
	import tdd_pkg::*;

	logic     ge;
	tdd_div_t step;

	// one stage of the divider chain
	logic      valid_sn;
	tdd_item_t item_sn;
	tdd_div_t  div_sn;

	// restoring division, DIV_STEPS quotient bits per stage
	always_comb begin
		step = up_div;
		ge   = 1'b0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			ge = (step.rem >= REM_W'(step.dsh));
			if (ge) begin
				step.rem = step.rem - REM_W'(step.dsh);
			end
			step.quo = {step.quo[QUO_W-2:0], ge};
			step.dsh = step.dsh >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (load) begin
			valid_sn <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && up_valid) begin
			item_sn <= up_item;
			div_sn  <= step;
		end
	end

	assign dn_valid = valid_sn;
	assign dn_item  = item_sn;
	assign dn_div   = div_sn;

endmodule
